// File: hw/rtl/esp_pkg.sv
package esp_pkg;

    localparam int NUM_SLOTS = 256;
    localparam int EMB_LEN   = 8;
    localparam int MAX_LANES = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int SUM_W     = 48;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 16;
    localparam int DIV_W     = $clog2(SUM_W);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        slot;
        logic signed [31:0] val0;
        logic signed [31:0] val1;
        logic signed [31:0] val2;
        logic signed [31:0] val3;
        logic signed [31:0] val4;
        logic signed [31:0] val5;
        logic signed [31:0] val6;
        logic signed [31:0] val7;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         slot_out;
        logic               present;
        logic               overflow;
        logic signed [31:0] avg0;
        logic signed [31:0] avg1;
        logic signed [31:0] avg2;
        logic signed [31:0] avg3;
        logic signed [31:0] avg4;
        logic signed [31:0] avg5;
        logic signed [31:0] avg6;
        logic signed [31:0] avg7;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              first;
        logic              div_start;
        logic              div_step;
        logic [SLOT_W-1:0] addr;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/esp_lane.sv
module esp_lane
    import esp_pkg::*;
(
    input  logic                    i_clk,
    input  t_lane_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_val,
    input  logic [CNT_W-1:0]        i_cnt,
    output logic                    o_sum_sat,
    output logic signed [VAL_W-1:0] o_avg,
    output logic                    o_avg_sat
);

    logic [SUM_W-1:0] r_mem [NUM_SLOTS];
    logic [SUM_W-1:0] r_rd;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W:0]   r_rem;
    logic             r_neg;

    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_new;
    logic [CNT_W:0]   rem_sh;
    logic             ge;

    always_comb begin
        sum_wide  = {r_rd[SUM_W-1], r_rd} + {{(SUM_W+1-VAL_W){i_val[VAL_W-1]}}, i_val};
        o_sum_sat = 1'b0;
        if (i_ctl.first) begin
            sum_new = {{(SUM_W-VAL_W){i_val[VAL_W-1]}}, i_val};
        end else if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            o_sum_sat = 1'b1;
            sum_new   = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_new = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.addr] <= sum_new;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.addr];
        end
    end

    // One quotient bit per cycle, restoring division on magnitudes.
    assign rem_sh = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, i_cnt};

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_start) begin
            r_neg <= r_rd[SUM_W-1];
            r_quo <= r_rd[SUM_W-1] ? (~r_rd + 1'b1) : r_rd;
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= ge ? (rem_sh - {1'b0, i_cnt}) : rem_sh;
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    always_comb begin
        o_avg_sat = 1'b0;
        if (r_neg) begin
            if (r_quo > {{(SUM_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}}) begin
                o_avg_sat = 1'b1;
                o_avg     = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                o_avg = -r_quo[VAL_W-1:0];
            end
        end else begin
            if (r_quo > {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}}) begin
                o_avg_sat = 1'b1;
                o_avg     = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                o_avg = r_quo[VAL_W-1:0];
            end
        end
    end

endmodule

// File: hw/rtl/esp_merge.sv
module esp_merge
    import esp_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_avg [MAX_LANES],
    input  logic [MAX_LANES-1:0]    i_avg_sat,
    input  logic [7:0]              i_slot,
    input  logic                    i_present,
    input  logic                    i_ovf,
    output logic                    o_avg_sat,
    output t_out_item               o_result
);

    always_comb begin
        o_avg_sat         = i_present & (|i_avg_sat);
        o_result.slot_out = i_slot;
        o_result.present  = i_present;
        o_result.overflow = i_present & (i_ovf | (|i_avg_sat));
        o_result.avg0     = i_present ? i_avg[0] : '0;
        o_result.avg1     = i_present ? i_avg[1] : '0;
        o_result.avg2     = i_present ? i_avg[2] : '0;
        o_result.avg3     = i_present ? i_avg[3] : '0;
        o_result.avg4     = i_present ? i_avg[4] : '0;
        o_result.avg5     = i_present ? i_avg[5] : '0;
        o_result.avg6     = i_present ? i_avg[6] : '0;
        o_result.avg7     = i_present ? i_avg[7] : '0;
    end

endmodule

// File: hw/rtl/embedding_slot_pooling_top.sv
// Add items take a table read, then an update and write back.
// Read items of a present slot pass through the 48-step bit-serial divider in each
// lane on the way to the output register; an absent slot skips the divider.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset clears the slot valid and overflow marks and control.
module embedding_slot_pooling_top
    import esp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    t_state r_state, n_state;

    logic                    r_cmd;
    logic [7:0]              r_slot;
    logic signed [VAL_W-1:0] r_val [MAX_LANES];
    logic [CNT_W-1:0]        r_cnt_mem [NUM_SLOTS];
    logic [CNT_W-1:0]        r_cnt_rd;
    logic [NUM_SLOTS-1:0]    r_vbits;
    logic [NUM_SLOTS-1:0]    r_obits;
    logic [DIV_W-1:0]        r_div_cnt;
    logic                    r_out_valid;
    t_out_item               r_out;

    t_lane_ctl               ctl;
    logic [SLOT_W-1:0]       idx;
    logic                    accept;
    logic                    cur_valid;
    logic [CNT_W-1:0]        div_cnt;
    logic [MAX_LANES-1:0]    sum_sat;
    logic [MAX_LANES-1:0]    avg_sat;
    logic signed [VAL_W-1:0] avg [MAX_LANES];
    logic                    merged_sat;
    t_out_item               merged;
    logic                    load_out;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign idx       = r_slot[SLOT_W-1:0];
    assign cur_valid = r_vbits[idx];
    assign div_cnt   = (r_cnt_rd == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : r_cnt_rd;
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        ctl           = '0;
        ctl.addr      = idx;
        ctl.first     = !cur_valid;
        case (r_state)
            S_IDLE: begin
                ctl.addr  = i_item.slot[SLOT_W-1:0];
                ctl.rd_en = accept;
                if (accept) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_cmd == CMD_ADD) begin
                    ctl.wr_en = 1'b1;
                    n_state   = S_IDLE;
                end else if (cur_valid) begin
                    ctl.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                ctl.div_step = 1'b1;
                if (r_div_cnt == DIV_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_item.cmd;
            r_slot   <= i_item.slot;
            r_val[0] <= i_item.val0;
            r_val[1] <= i_item.val1;
            r_val[2] <= i_item.val2;
            r_val[3] <= i_item.val3;
            r_val[4] <= i_item.val4;
            r_val[5] <= i_item.val5;
            r_val[6] <= i_item.val6;
            r_val[7] <= i_item.val7;
            r_cnt_rd <= r_cnt_mem[i_item.slot[SLOT_W-1:0]];
        end
        if (r_state == S_ACC && r_cmd == CMD_ADD) begin
            if (!cur_valid) begin
                r_cnt_mem[idx] <= {{(CNT_W-1){1'b0}}, 1'b1};
            end else if (r_cnt_rd != COUNT_MAX) begin
                r_cnt_mem[idx] <= r_cnt_rd + 1'b1;
            end
        end
        if (r_state == S_ACC) begin
            r_div_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (load_out) begin
            r_out <= merged;
        end
    end

    // Valid and overflow marks per slot live in flip-flops so reset clears them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
            r_obits <= '0;
        end else if (r_state == S_ACC && r_cmd == CMD_ADD) begin
            r_vbits[idx] <= 1'b1;
            if (!cur_valid) begin
                r_obits[idx] <= 1'b0;
            end else if ((|sum_sat) || r_cnt_rd == COUNT_MAX) begin
                r_obits[idx] <= 1'b1;
            end
        end else if (load_out && merged_sat) begin
            r_obits[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LANES; g++) begin : g_lane
            if (g < EMB_LEN) begin : g_used
                esp_lane u_lane (
                    .i_clk     (i_clk),
                    .i_ctl     (ctl),
                    .i_val     (r_val[g]),
                    .i_cnt     (div_cnt),
                    .o_sum_sat (sum_sat[g]),
                    .o_avg     (avg[g]),
                    .o_avg_sat (avg_sat[g])
                );
            end else begin : g_unused
                assign sum_sat[g] = 1'b0;
                assign avg[g]     = '0;
                assign avg_sat[g] = 1'b0;
            end
        end
    endgenerate

    esp_merge u_merge (
        .i_avg     (avg),
        .i_avg_sat (avg_sat),
        .i_slot    (r_slot),
        .i_present (cur_valid),
        .i_ovf     (r_obits[idx]),
        .o_avg_sat (merged_sat),
        .o_result  (merged)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: hw/rtl/esp_checker.sv
module esp_checker
    import esp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_result
);

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken on consecutive cycles");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.present |->
            !o_result.overflow && o_result.avg0 == 0 && o_result.avg7 == 0)
        else $error("absent slot returned data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

endmodule

bind embedding_slot_pooling_top esp_checker u_esp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
